@@ sv/sensor_health_hourly_buckets_defines.svh @@
// ----------------------------------------------------------------------------
// Sensor health hourly buckets: assertion macros
// Shared concurrent check forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SENSOR_HEALTH_HOURLY_BUCKETS_DEFINES_SVH
`define SENSOR_HEALTH_HOURLY_BUCKETS_DEFINES_SVH

// same-cycle implication, held off during reset
`define SHB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shb check failed");

// next-cycle implication, held off during reset
`define SHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shb check failed");

`endif

@@ sv/shb_pkg.sv @@
// ----------------------------------------------------------------------------
// shb_pkg
// Types and codes shared by the sensor health bucket controller and datapath.
// ----------------------------------------------------------------------------
package shb_pkg;

    // result outcome codes
    localparam logic [2:0] OUT_READ         = 3'd0;
    localparam logic [2:0] OUT_ERROR        = 3'd1;
    localparam logic [2:0] OUT_SLEEP        = 3'd2;
    localparam logic [2:0] OUT_RATE_LIMITED = 3'd3;
    localparam logic [2:0] OUT_REPORT       = 3'd4;

    // bucket status codes
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_WARN    = 2'd2;
    localparam logic [1:0] ST_ERR     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DATA_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_EMPTY_IS_ERR  = 2'd1;
    localparam logic [1:0] CFG_PERIODIC      = 2'd2;
    localparam logic [1:0] CFG_SLOT_LENGTH   = 2'd3;

    // request types
    localparam logic REQ_POLL   = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // quotient bits produced by the divider, one per cycle
    localparam int DIV_STEPS = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ROT,
        S_ROT_STEP,
        S_RD,
        S_UPD,
        S_HOLD,
        S_RPT_RD,
        S_RPT_LD,
        S_RPT_HOLD
    } shb_state_t;

    typedef struct packed {
        logic cap_poll;   // latch poll, start divider
        logic cap_rpt;    // latch report, set oldest bucket pointer
        logic rot_set;    // apply quotient: new slot start, jump or set step count
        logic rot_step;   // advance one bucket and clear it
        logic rd_cur;     // read current bucket
        logic upd;        // update current bucket, load result
        logic rpt_rd;     // read bucket at report pointer
        logic rpt_ld;     // load report result, advance pointer
    } shb_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic k_step;     // quotient nonzero and below the ring size
        logic steps_one;  // last rotate step
        logic out_valid;
        logic out_last;
    } shb_sts_t;

endpackage

@@ sv/shb_ram.sv @@
// ----------------------------------------------------------------------------
// shb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 24
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/shb_div.sv @@
// ----------------------------------------------------------------------------
// shb_div
// Restoring divider, one quotient bit per cycle; also keeps quotient mod SLOTS.
// ----------------------------------------------------------------------------
module shb_div import shb_pkg::*; #(
    parameter int SLOTS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [31:0]              dividend,
    input  logic [30:0]              divisor,
    output logic                     busy,
    output logic [31:0]              quot,
    output logic [30:0]              rem,
    output logic [$clog2(SLOTS)-1:0] qmod
);

    localparam int SW   = $clog2(SLOTS);
    localparam int CNTW = $clog2(DIV_STEPS);
    localparam logic [SW:0]     SLOTS_W  = (SW+1)'(SLOTS);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DIV_STEPS - 1);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [31:0]     dvd_reg;
    logic [30:0]     dsr_reg;
    logic [30:0]     rem_reg, rem_next;
    logic [SW-1:0]   qm_reg, qm_next;
    logic [31:0]     rem_sh, diff;
    logic            ge;
    logic [SW:0]     qm2;

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[31]};
        diff     = rem_sh - {1'b0, dsr_reg};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_next = ge ? diff[30:0] : rem_sh[30:0];
        qm2      = {qm_reg, ge};
        qm_next  = (qm2 >= SLOTS_W) ? SW'(qm2 - SLOTS_W) : qm2[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            qm_reg  <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[30:0], ge};
            rem_reg <= rem_next;
            qm_reg  <= qm_next;
        end
    end

    assign busy = busy_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;
    assign qmod = qm_reg;

endmodule

@@ sv/shb_dp.sv @@
// ----------------------------------------------------------------------------
// shb_dp
// Datapath: config, time state, bucket ring with valid bits, result register.
// ----------------------------------------------------------------------------
module shb_dp import shb_pkg::*; #(
    parameter int SLOTS        = 24,
    parameter int COUNT_WIDTH  = 16,
    parameter int MAX_READINGS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  shb_cmd_t                              cmd,
    output shb_sts_t                              sts,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [30:0]                           cfg_wdata,
    input  logic [31:0]                           s_now_ms,
    input  logic [$clog2(MAX_READINGS+1)-1:0]     s_reading_count,
    input  logic [31:0]                           s_latency_us,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [2:0]                            m_outcome,
    output logic                                  m_recovered,
    output logic [COUNT_WIDTH-1:0]                m_bucket_reads,
    output logic [COUNT_WIDTH-1:0]                m_bucket_errors,
    output logic [31:0]                           m_bucket_latency_us,
    output logic [1:0]                            m_bucket_status,
    output logic                                  m_last_item
);

    localparam int CW = COUNT_WIDTH;
    localparam int SW = $clog2(SLOTS);
    localparam int RW = 32 + 2*CW;
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
    localparam logic [SW:0]   SLOTS_W   = (SW+1)'(SLOTS);

    function automatic logic [1:0] status_of(input logic [CW-1:0] r, input logic [CW-1:0] e);
        logic [1:0] st;
        if (r == '0 && e == '0) st = ST_UNKNOWN;
        else if (e == '0) st = ST_OK;
        else if ({e, 2'b00} < {2'b00, r}) st = ST_WARN;
        else st = ST_ERR;
        return st;
    endfunction

    // configuration
    logic [30:0] interval_reg, slot_len_reg;
    logic        empty_err_reg, periodic_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= 31'd1000;
            empty_err_reg <= 1'b1;
            periodic_reg  <= 1'b0;
            slot_len_reg  <= 31'd3600000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DATA_INTERVAL: interval_reg  <= cfg_wdata;
                CFG_EMPTY_IS_ERR:  empty_err_reg <= cfg_wdata[0];
                CFG_PERIODIC:      periodic_reg  <= cfg_wdata[0];
                CFG_SLOT_LENGTH:   slot_len_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // time state
    logic [SW-1:0] cur_reg, cur_next, cur_inc;
    logic [31:0]   slot_start_reg, first_seen_reg, last_success_reg, last_error_reg;
    logic          started_reg, success_valid_reg;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SW-1:0] steps_reg;
    logic [SW-1:0] ptr_reg, rcnt_reg, ptr_inc;
    logic [SW:0]   jump_sum;

    // captured poll
    logic [31:0] ms_reg, lat_reg;
    logic        cnt_nz_reg;

    // divider
    logic [31:0]   div_dvd;
    logic [30:0]   div_dsr;
    logic          div_busy;
    logic [31:0]   div_quot;
    logic [30:0]   div_rem;
    logic [SW-1:0] div_qmod;
    logic          k_zero, k_big;

    assign div_dvd = started_reg ? (s_now_ms - slot_start_reg) : 32'd0;
    assign div_dsr = (slot_len_reg == '0) ? 31'd1 : slot_len_reg;

    shb_div #(.SLOTS(SLOTS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.cap_poll),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem),
        .qmod     (div_qmod)
    );

    assign k_zero = (div_quot == '0);
    assign k_big  = (div_quot >= 32'(SLOTS));

    // bucket store
    logic          ram_we;
    logic [SW-1:0] ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic          rd_valid_reg;

    assign ram_raddr = cmd.rd_cur ? cur_reg : ptr_reg;

    shb_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // bucket contents, never-written entries read as zero
    logic [CW-1:0] b_reads, b_errs, n_reads, n_errs;
    logic [31:0]   b_lat, n_lat;
    logic [31:0]   ref_ms, since_ref, since_err;
    logic          sleep, err_due;
    logic [2:0]    upd_outcome;

    always_comb begin
        b_reads = rd_valid_reg ? ram_rdata[CW-1:0]    : '0;
        b_errs  = rd_valid_reg ? ram_rdata[2*CW-1:CW] : '0;
        b_lat   = rd_valid_reg ? ram_rdata[RW-1:2*CW] : '0;

        ref_ms    = success_valid_reg ? last_success_reg : first_seen_reg;
        since_ref = ms_reg - ref_ms;
        since_err = ms_reg - last_error_reg;
        sleep     = !empty_err_reg && ({1'b0, since_ref} <= {1'b0, interval_reg, 1'b0});
        err_due   = empty_err_reg || (since_err >= {1'b0, interval_reg});

        n_reads     = b_reads;
        n_errs      = b_errs;
        n_lat       = b_lat;
        upd_outcome = OUT_RATE_LIMITED;
        if (cnt_nz_reg) begin
            if (b_reads != '1) n_reads = b_reads + 1'b1;
            n_lat       = b_lat + lat_reg;
            upd_outcome = OUT_READ;
        end else if (sleep) begin
            upd_outcome = OUT_SLEEP;
        end else if (err_due) begin
            if (b_errs != '1) n_errs = b_errs + 1'b1;
            upd_outcome = OUT_ERROR;
        end
        ram_we    = cmd.upd;
        ram_wdata = {n_lat, n_errs, n_reads};
    end

    // ring pointers
    always_comb begin
        cur_inc  = (cur_reg == SLOT_LAST) ? '0 : cur_reg + 1'b1;
        ptr_inc  = (ptr_reg == SLOT_LAST) ? '0 : ptr_reg + 1'b1;
        jump_sum = {1'b0, cur_reg} + {1'b0, div_qmod};
        cur_next = cur_reg;
        valid_next = valid_reg;
        if (cmd.rot_set && k_big) begin
            cur_next   = (jump_sum >= SLOTS_W) ? SW'(jump_sum - SLOTS_W) : jump_sum[SW-1:0];
            valid_next = '0;
        end
        if (cmd.rot_step) begin
            cur_next            = cur_inc;
            valid_next[cur_inc] = 1'b0;
        end
        if (cmd.upd) begin
            valid_next[cur_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg           <= '0;
            valid_reg         <= '0;
            started_reg       <= 1'b0;
            success_valid_reg <= 1'b0;
            slot_start_reg    <= '0;
            first_seen_reg    <= '0;
            last_success_reg  <= '0;
            last_error_reg    <= '0;
        end else begin
            cur_reg   <= cur_next;
            valid_reg <= valid_next;
            if (cmd.cap_poll && !started_reg) begin
                started_reg    <= 1'b1;
                slot_start_reg <= s_now_ms;
                first_seen_reg <= s_now_ms;
            end
            // slot start advances by whole slots: poll time minus remainder
            if (cmd.rot_set) begin
                slot_start_reg <= ms_reg - {1'b0, div_rem};
            end
            if (cmd.upd && cnt_nz_reg) begin
                last_success_reg  <= ms_reg;
                success_valid_reg <= 1'b1;
            end
            if (cmd.upd && !cnt_nz_reg && !sleep && err_due) begin
                last_error_reg <= ms_reg;
            end
        end
    end

    // payload-only registers
    always_ff @(posedge aclk) begin
        if (cmd.cap_poll) begin
            ms_reg     <= s_now_ms;
            lat_reg    <= s_latency_us;
            cnt_nz_reg <= (s_reading_count != '0);
        end
        if (cmd.rot_set) begin
            steps_reg <= div_quot[SW-1:0];
        end else if (cmd.rot_step) begin
            steps_reg <= steps_reg - 1'b1;
        end
        if (cmd.cap_rpt) begin
            ptr_reg  <= cur_inc;
            rcnt_reg <= '0;
        end else if (cmd.rpt_ld) begin
            ptr_reg  <= ptr_inc;
            rcnt_reg <= rcnt_reg + 1'b1;
        end
        if (cmd.rd_cur || cmd.rpt_rd) begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
    end

    // result register
    logic          out_valid_reg;
    logic [2:0]    out_outcome_reg;
    logic          out_rec_reg, out_last_reg;
    logic [CW-1:0] out_reads_reg, out_errs_reg;
    logic [31:0]   out_lat_reg;
    logic [1:0]    out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.upd || cmd.rpt_ld) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            out_outcome_reg <= upd_outcome;
            out_rec_reg     <= cnt_nz_reg & periodic_reg;
            out_reads_reg   <= n_reads;
            out_errs_reg    <= n_errs;
            out_lat_reg     <= n_lat;
            out_status_reg  <= status_of(n_reads, n_errs);
            out_last_reg    <= 1'b1;
        end else if (cmd.rpt_ld) begin
            out_outcome_reg <= OUT_REPORT;
            out_rec_reg     <= 1'b0;
            out_reads_reg   <= b_reads;
            out_errs_reg    <= b_errs;
            out_lat_reg     <= b_lat;
            out_status_reg  <= status_of(b_reads, b_errs);
            out_last_reg    <= (rcnt_reg == SLOT_LAST);
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_outcome           = out_outcome_reg;
    assign m_recovered         = out_rec_reg;
    assign m_bucket_reads      = out_reads_reg;
    assign m_bucket_errors     = out_errs_reg;
    assign m_bucket_latency_us = out_lat_reg;
    assign m_bucket_status     = out_status_reg;
    assign m_last_item         = out_last_reg;

    assign sts.div_busy  = div_busy;
    assign sts.k_step    = !k_zero && !k_big;
    assign sts.steps_one = (steps_reg == SW'(1));
    assign sts.out_valid = out_valid_reg;
    assign sts.out_last  = out_last_reg;

endmodule

@@ sv/shb_ctrl.sv @@
// ----------------------------------------------------------------------------
// shb_ctrl
// Sequencer for poll and report requests.
// ----------------------------------------------------------------------------
module shb_ctrl import shb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_req_type,
    output logic       s_ready,
    input  logic       m_ready,
    input  shb_sts_t   sts,
    output shb_cmd_t   cmd,
    output shb_state_t state
);

    shb_state_t state_reg, state_next;
    logic       take, out_take;

    // nothing is taken while reset is held
    assign take     = s_valid && aresetn && (state_reg == S_IDLE);
    assign out_take = sts.out_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (take) state_next = (s_req_type == REQ_REPORT) ? S_RPT_RD : S_DIV;
            end
            S_DIV: begin
                if (!sts.div_busy) state_next = S_ROT;
            end
            S_ROT: begin
                state_next = sts.k_step ? S_ROT_STEP : S_RD;
            end
            S_ROT_STEP: begin
                if (sts.steps_one) state_next = S_RD;
            end
            S_RD:     state_next = S_UPD;
            S_UPD:    state_next = S_HOLD;
            S_HOLD: begin
                if (out_take) state_next = S_IDLE;
            end
            S_RPT_RD: state_next = S_RPT_LD;
            S_RPT_LD: state_next = S_RPT_HOLD;
            S_RPT_HOLD: begin
                if (out_take) state_next = sts.out_last ? S_IDLE : S_RPT_LD;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready      = aresetn;
                cmd.cap_poll = take && (s_req_type == REQ_POLL);
                cmd.cap_rpt  = take && (s_req_type == REQ_REPORT);
            end
            S_ROT:      cmd.rot_set  = 1'b1;
            S_ROT_STEP: cmd.rot_step = 1'b1;
            S_RD:       cmd.rd_cur   = 1'b1;
            S_UPD:      cmd.upd      = 1'b1;
            S_RPT_RD:   cmd.rpt_rd   = 1'b1;
            S_RPT_LD:   cmd.rpt_ld   = 1'b1;
            S_RPT_HOLD: cmd.rpt_rd   = out_take && !sts.out_last;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

@@ sv/sensor_health_hourly_buckets.sv @@
// ----------------------------------------------------------------------------
// sensor_health_hourly_buckets
// Health monitor for one sensor over a ring of SLOTS time buckets.
// ----------------------------------------------------------------------------
//
//  channel | ports                  | moves
//  --------+------------------------+------------------------------------------
//  s_      | s_valid / s_ready      | request: poll outcome or bucket report
//  m_      | m_valid / m_ready      | result: 1 per poll, SLOTS per report
//  cfg_    | cfg_we, index, wdata   | register write, taken on any clock edge with cfg_we high
//
//  Poll: accept, divide (32 quotient bits, then busy drops), apply the quotient,
//  then k ring steps (k below SLOTS, one bucket cleared per cycle), read, update, result wait.
//  Report: oldest bucket first, paced by the registered RAM read and by m_ready.
//  Reset clears the bucket valid bits at once; no clearing pass is run.
//  One request is worked at a time; s_ready drops until its last result
//  has been taken, and a stalled m_ready holds the result register.
//
`include "sensor_health_hourly_buckets_defines.svh"

module sensor_health_hourly_buckets import shb_pkg::*; #(
    parameter int SLOTS        = 24,
    parameter int COUNT_WIDTH  = 16,
    parameter int MAX_READINGS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [30:0]                       cfg_wdata,
    // requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [31:0]                       s_now_ms,
    input  logic [$clog2(MAX_READINGS+1)-1:0] s_reading_count,
    input  logic [31:0]                       s_latency_us,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_outcome,
    output logic                              m_recovered,
    output logic [COUNT_WIDTH-1:0]            m_bucket_reads,
    output logic [COUNT_WIDTH-1:0]            m_bucket_errors,
    output logic [31:0]                       m_bucket_latency_us,
    output logic [1:0]                        m_bucket_status,
    output logic                              m_last_item
);

    shb_cmd_t   cmd;
    shb_sts_t   sts;
    shb_state_t state;

    // controller: sequences divide, ring rotation, update and report streaming
    shb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd),
        .state      (state)
    );

    // datapath: config, time state, bucket RAM, result register
    shb_dp #(
        .SLOTS        (SLOTS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .MAX_READINGS (MAX_READINGS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_now_ms            (s_now_ms),
        .s_reading_count     (s_reading_count),
        .s_latency_us        (s_latency_us),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_outcome           (m_outcome),
        .m_recovered         (m_recovered),
        .m_bucket_reads      (m_bucket_reads),
        .m_bucket_errors     (m_bucket_errors),
        .m_bucket_latency_us (m_bucket_latency_us),
        .m_bucket_status     (m_bucket_status),
        .m_last_item         (m_last_item)
    );

    // a new request is never taken while a result is pending
    `SHB_ASSERT_NOW(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    // a poll gives exactly one result
    `SHB_ASSERT_NOW(a_poll_single, aclk, aresetn,
        m_valid && (m_outcome != OUT_REPORT), m_last_item)
    // report results never flag recovery
    `SHB_ASSERT_NOW(a_rpt_no_rec, aclk, aresetn,
        m_valid && (m_outcome == OUT_REPORT), !m_recovered)
    // nothing follows the final result of a request, and the sequencer is idle
    `SHB_ASSERT_NEXT(a_last_ends, aclk, aresetn,
        m_valid && m_ready && m_last_item, !m_valid && (state == S_IDLE))

endmodule

@@ dv/tb_sensor_health_hourly_buckets.sv @@
// ----------------------------------------------------------------------------
// tb_sensor_health_hourly_buckets
// Self-checking bench for the sensor health bucket monitor. Polls and bucket
// reports go in over s_, results come back over m_, and each result is checked
// against a cycle-free model of the 24-bucket ring kept inside the bench.
// Directed requests cover the first-poll, sleep, rate-limit and register
// extremes; random phases then cover the rest, most with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sensor_health_hourly_buckets;
    import shb_pkg::*;

    localparam int RING          = 24;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 80;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int MAX_REPORTED  = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 42;

    // one result as it appears on the m_ ports
    typedef struct packed {
        logic [2:0]  outcome;
        logic        recovered;
        logic [15:0] reads;
        logic [15:0] errors;
        logic [31:0] latency;
        logic [1:0]  status;
        logic        last;
    } health_result_t;

    // ------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [1:0]  cfg_index       = CFG_DATA_INTERVAL;
    logic [30:0] cfg_wdata       = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_req_type      = REQ_POLL;
    logic [31:0] s_now_ms        = '0;
    logic [3:0]  s_reading_count = '0;
    logic [31:0] s_latency_us    = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [2:0]  m_outcome;
    logic        m_recovered;
    logic [15:0] m_bucket_reads;
    logic [15:0] m_bucket_errors;
    logic [31:0] m_bucket_latency_us;
    logic [1:0]  m_bucket_status;
    logic        m_last_item;

    always #CLK_HALF aclk = ~aclk;

    sensor_health_hourly_buckets dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_now_ms            (s_now_ms),
        .s_reading_count     (s_reading_count),
        .s_latency_us        (s_latency_us),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_outcome           (m_outcome),
        .m_recovered         (m_recovered),
        .m_bucket_reads      (m_bucket_reads),
        .m_bucket_errors     (m_bucket_errors),
        .m_bucket_latency_us (m_bucket_latency_us),
        .m_bucket_status     (m_bucket_status),
        .m_last_item         (m_last_item)
    );

    // ------------------------------------------------------------------
    // Health model: register copies and ring state, reset values
    // ------------------------------------------------------------------
    logic [30:0] interval_ms   = 31'd1000;
    logic        empty_is_err  = 1'b1;
    logic        periodic      = 1'b0;
    logic [30:0] slot_len_ms   = 31'd3600000;

    int unsigned ring_pos      = 0;
    logic [31:0] slot_start    = '0;
    logic [31:0] first_seen    = '0;
    logic [31:0] last_read_ms  = '0;
    logic [31:0] last_error_ms = '0;
    bit          slot_started  = 1'b0;
    bit          seen_any      = 1'b0;
    bit          read_any      = 1'b0;
    logic [15:0] bucket_reads  [RING];
    logic [15:0] bucket_errors [RING];
    logic [31:0] bucket_lat    [RING];

    health_result_t pending_results[$];

    // bench bookkeeping
    int          bad_count   = 0;
    int          cycle_count = 0;
    int          ready_hold  = 0;
    bit          steady      = 1'b0;   // no idling on either side while set
    logic [31:0] poll_clock  = '0;

    initial begin
        for (int i = 0; i < RING; i++) begin
            bucket_reads[i]  = '0;
            bucket_errors[i] = '0;
            bucket_lat[i]    = '0;
        end
    end

    function automatic logic [1:0] status_of(logic [15:0] r, logic [15:0] e);
        if (r == 0 && e == 0) return ST_UNKNOWN;
        if (e == 0) return ST_OK;
        if ((32'(e) * 4) < 32'(r)) return ST_WARN;
        return ST_ERR;
    endfunction

    function automatic health_result_t bucket_view(logic [2:0] oc, logic rec,
                                                   int unsigned idx, logic last);
        health_result_t v;
        v.outcome   = oc;
        v.recovered = rec;
        v.reads     = bucket_reads[idx];
        v.errors    = bucket_errors[idx];
        v.latency   = bucket_lat[idx];
        v.status    = status_of(bucket_reads[idx], bucket_errors[idx]);
        v.last      = last;
        return v;
    endfunction

    function automatic void clear_bucket(int unsigned idx);
        bucket_reads[idx]  = '0;
        bucket_errors[idx] = '0;
        bucket_lat[idx]    = '0;
    endfunction

    // move the ring forward to the bucket covering ms, clearing each one entered
    function automatic void advance_ring(logic [31:0] ms);
        logic [31:0] len;
        logic [31:0] steps;
        len   = (slot_len_ms == 0) ? 32'd1 : {1'b0, slot_len_ms};
        steps = (ms - slot_start) / len;
        if (steps == 0) return;
        if (steps >= RING) begin
            // gap of a full ring or more: everything goes
            for (int i = 0; i < RING; i++) clear_bucket(i);
            ring_pos = (ring_pos + steps % RING) % RING;
        end else begin
            for (int i = 0; i < steps; i++) begin
                ring_pos = (ring_pos + 1) % RING;
                clear_bucket(ring_pos);
            end
        end
        slot_start = slot_start + steps * len;
    endfunction

    // work out the results of one accepted request and queue them
    function automatic void predict_request(logic req, logic [31:0] ms,
                                            logic [3:0] cnt, logic [31:0] lat);
        int unsigned pos;
        logic [2:0]  oc;
        logic        rec;
        logic        asleep;
        logic [31:0] anchor_ms;
        if (req == REQ_REPORT) begin
            // oldest bucket first, the current one closes the request
            pos = (ring_pos + 1) % RING;
            for (int b = 0; b < RING; b++) begin
                pending_results.push_back(bucket_view(OUT_REPORT, 1'b0, pos, b == RING - 1));
                pos = (pos + 1) % RING;
            end
            return;
        end
        // a poll at time zero is an ordinary time: the flags mark the latch
        if (!slot_started) begin
            slot_start   = ms;
            slot_started = 1'b1;
        end
        if (!seen_any) begin
            first_seen = ms;
            seen_any   = 1'b1;
        end
        advance_ring(ms);
        rec = 1'b0;
        if (cnt != 0) begin
            if (bucket_reads[ring_pos] != 16'hFFFF) bucket_reads[ring_pos]++;
            bucket_lat[ring_pos] = bucket_lat[ring_pos] + lat;
            rec          = periodic;
            last_read_ms = ms;
            read_any     = 1'b1;
            oc           = OUT_READ;
        end else begin
            asleep = 1'b0;
            if (!empty_is_err) begin
                // no read yet: the sleep window runs from the first poll
                anchor_ms = read_any ? last_read_ms : first_seen;
                asleep    = ((ms - anchor_ms) <= {interval_ms, 1'b0});
            end
            if (asleep) begin
                oc = OUT_SLEEP;
            end else if (empty_is_err || ((ms - last_error_ms) >= {1'b0, interval_ms})) begin
                if (bucket_errors[ring_pos] != 16'hFFFF) bucket_errors[ring_pos]++;
                last_error_ms = ms;
                oc            = OUT_ERROR;
            end else begin
                oc = OUT_RATE_LIMITED;
            end
        end
        pending_results.push_back(bucket_view(oc, rec, ring_pos, 1'b1));
    endfunction

    function automatic string describe(health_result_t v);
        return $sformatf("outcome=%0d rec=%0d reads=%0d errors=%0d lat=%08h status=%0d last=%0d",
                         v.outcome, v.recovered, v.reads, v.errors, v.latency,
                         v.status, v.last);
    endfunction

    // ------------------------------------------------------------------
    // Result side: m_ready stalls drawn per result, checked at the edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        health_result_t want;
        health_result_t got;
        if (aresetn && m_valid && m_ready) begin
            ready_hold <= steady ? 0 : $urandom_range(0, 10);
            got = '{m_outcome, m_recovered, m_bucket_reads, m_bucket_errors,
                    m_bucket_latency_us, m_bucket_status, m_last_item};
            if (pending_results.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTED)
                    $display("%0t: result with nothing expected: %s", $realtime, describe(got));
            end else begin
                want = pending_results.pop_front();
                if (got.outcome !== want.outcome || got.recovered !== want.recovered ||
                    got.reads !== want.reads || got.errors !== want.errors ||
                    got.latency !== want.latency || got.status !== want.status ||
                    got.last !== want.last) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTED) begin
                        $display("%0t: result mismatch", $realtime);
                        $display("    expected %s", describe(want));
                        $display("    actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // one request: random gap, then hold valid and payload until taken
    task automatic send_request(logic req, logic [31:0] ms, logic [3:0] cnt,
                                logic [31:0] lat);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_now_ms        <= ms;
        s_reading_count <= cnt;
        s_latency_us    <= lat;
        do @(posedge aclk); while (!s_ready);
        predict_request(req, ms, cnt, lat);
    endtask

    task automatic send_poll(logic [31:0] ms, logic [3:0] cnt, logic [31:0] lat);
        send_request(REQ_POLL, ms, cnt, lat);
    endtask

    // payload of a report is don't-care, so it gets noise
    task automatic send_report();
        send_request(REQ_REPORT, $urandom(), 4'($urandom()), $urandom());
    endtask

    // stop sending, let every expected result come back, then let the block settle
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [30:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DATA_INTERVAL: interval_ms  = val;
            CFG_EMPTY_IS_ERR:  empty_is_err = val[0];
            CFG_PERIODIC:      periodic     = val[0];
            CFG_SLOT_LENGTH:   slot_len_ms  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // only with the block idle; flag registers get noise in the unused bits
    task automatic apply_settings(logic [30:0] ivl, logic empty_err, logic periodic_on,
                                  logic [30:0] len);
        wait_for_results();
        write_register(CFG_DATA_INTERVAL, ivl);
        write_register(CFG_EMPTY_IS_ERR, {30'($urandom()), empty_err});
        write_register(CFG_PERIODIC, {30'($urandom()), periodic_on});
        write_register(CFG_SLOT_LENGTH, len);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // fresh block: empty report, first polls at time zero, sleep from the first
    // poll, early miss inside the rate limit, wide counts, latency wrap
    task automatic test_first_polls();
        apply_settings(31'd1000, 1'b0, 1'b1, 31'd100);
        send_report();
        send_poll(32'd0, 4'd0, 32'd99);             // sleep, window from first poll
        send_poll(32'd0, 4'd1, 32'd7);              // read, recovered
        send_poll(32'd150, 4'd15, 32'hFFFF_FFFF);   // next bucket, widest count
        send_poll(32'd100, 4'd0, 32'd0);            // miss near time zero: rate limited
        send_poll(32'd160, 4'd8, 32'hFFFF_FFF0);    // latency sum wraps
        send_poll(32'd170, 4'd0, 32'd0);            // inside sleep window
        send_report();
    endtask

    // zero slot length acts as 1 ms; every empty poll is an error
    task automatic test_zero_slot_length();
        apply_settings(31'h7FFF_FFFF, 1'b1, 1'b0, 31'd0);
        send_poll(32'd200, 4'd0, 32'd1);
        send_poll(32'd210, 4'd3, 32'd0);            // ten buckets on
        send_poll(32'hFFFF_FFFF, 4'd0, 32'd5);      // whole ring cleared
        send_poll(32'hFFFF_FFFF, 4'd1, 32'd12345);  // same bucket, no recovery flag
        send_report();
    endtask

    // widest interval and slot length, sleep window across the wrap
    task automatic test_widest_settings();
        apply_settings(31'h7FFF_FFFF, 1'b0, 1'b1, 31'h7FFF_FFFF);
        send_poll(32'h7FFF_FFFF, 4'd0, 32'd0);      // half the clock away: still sleep
        send_poll(32'd0, 4'd0, 32'd0);              // one past the last read
        send_poll(32'hFFFF_FFFE, 4'd0, 32'd0);      // just outside the window: error
        send_report();
    endtask

    task automatic random_poll();
        int unsigned ivl;
        int unsigned len;
        logic [3:0]  cnt;
        logic [31:0] lat;
        ivl = (interval_ms > 5000) ? 5000 : interval_ms;
        len = (slot_len_ms > 100000) ? 100000 : ((slot_len_ms == 0) ? 1 : slot_len_ms);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: poll_clock = poll_clock + $urandom_range(0, 3 * ivl + 4);
            5, 6, 7:       poll_clock = poll_clock + $urandom_range(0, 3 * len);
            8:             poll_clock = poll_clock + len * $urandom_range(20, 30);
            default:       poll_clock = $urandom();
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cnt = 4'd0;
            9:          cnt = 4'($urandom_range(9, 15));
            default:    cnt = 4'($urandom_range(1, 8));
        endcase
        lat = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 5000));
        send_poll(poll_clock, cnt, lat);
    endtask

    // random phases with fresh settings each; some run without idling
    task automatic test_random_traffic();
        logic [30:0] ivl;
        logic [30:0] len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       ivl = 31'd0;
                1:       ivl = 31'h7FFF_FFFF;
                default: ivl = 31'($urandom_range(1, 3000));
            endcase
            case ($urandom_range(0, 6))
                0:       len = 31'd1;
                1:       len = 31'd3600000;
                2:       len = 31'h7FFF_FFFF;
                default: len = 31'($urandom_range(2, 600));
            endcase
            apply_settings(ivl, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), len);
            steady = (phase % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // now and then hold off until the block has drained
                if ($urandom_range(0, 24) == 0) wait_for_results();
                if ($urandom_range(0, 7) == 0) send_report();
                else random_poll();
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        poll_clock = 32'hFFFF_FFFE;
        test_first_polls();
        test_zero_slot_length();
        test_widest_settings();
        test_random_traffic();
        wait_for_results();
        if (bad_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sensor_health_hourly_buckets.f @@
+incdir+sv
sv/shb_pkg.sv
sv/shb_ram.sv
sv/shb_div.sv
sv/shb_dp.sv
sv/shb_ctrl.sv
sv/sensor_health_hourly_buckets.sv
dv/tb_sensor_health_hourly_buckets.sv
